// ===== src/lzssd_pkg.sv =====
// shared types and constants for the lzss decompressor
package lzssd_pkg;

    localparam int WIN_BITS = 12;
    localparam logic [WIN_BITS:0] WIN_SIZE = 13'd4096;
    localparam logic [WIN_BITS-1:0] OFFSET_BIAS = 12'd4078;
    localparam logic [4:0] MIN_LEN = 5'd3;
    localparam logic [3:0] FLAG_COUNT = 4'd8;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_CLR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [7:0]          lit;
        logic [WIN_BITS-1:0] offset;
        logic [3:0]          len_code;
        logic                last;
    } t_cmd;

    typedef enum logic {
        PH_TOKEN,
        PH_REF_HI
    } t_phase;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } t_back_state;

endpackage

// ===== src/lzss_decompressor_core.sv =====
// lzss decompressor top level: parser, command queue and copy engine
//
// compressed payload enters on the s_axis channel one byte per item, tlast on
// the final byte of a stream; decompressed bytes leave on m_axis one per item,
// tlast set on the last byte produced by a given input item
// a flag byte is read lsb first: a set bit is a literal, a clear bit a two-byte
// reference into a 4096-byte history window giving 3 to 18 bytes
// the parser takes an input item every cycle while the command queue has room,
// so input and output stall independently
// a literal passes the command queue, the read stage and the output register on its
// way to m_axis; a reference first sets up the copy in the idle state and then
// gives one byte per cycle while m_axis does not stall
// the window memory has one write and one registered read port, which is what
// limits the engine to one byte per cycle
// a stall on m_axis holds the output register and the read stage; the queue
// then fills and s_axis tready drops
// reset clears parser, queue and engine; the window is not cleared, bytes
// before the stream start read as zero
module lzss_decompressor_core
    import lzssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_byte
    output logic       o_m_axis_tlast
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    lzssd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_ready (w_q_ready)
    );

    lzssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    lzssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ===== src/lzssd_front.sv =====
// input parser: flag bits, literals and reference pairs turned into commands
module lzssd_front
    import lzssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_q_ready
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_flag_bits, n_flag_bits;
    logic [3:0] r_flags_left, n_flags_left;
    logic [7:0] r_held, n_held;
    logic       w_accept;
    logic       w_has_cmd;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign o_push   = w_accept && w_has_cmd;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                PH_REF_HI: n_phase = PH_TOKEN;
                PH_TOKEN: begin
                    if (r_flags_left != 4'd0 && !r_flag_bits[0]) begin
                        n_phase = PH_REF_HI;
                    end
                end
                default: n_phase = PH_TOKEN;
            endcase
            if (i_last) begin
                n_phase = PH_TOKEN;
            end
        end
    end

    // command and flag state
    always_comb begin
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_held       = r_held;
        w_has_cmd    = 1'b0;
        o_cmd.kind     = CMD_CLR;
        o_cmd.lit      = i_byte;
        o_cmd.offset   = {i_byte[7:4], r_held};
        o_cmd.len_code = i_byte[3:0];
        o_cmd.last     = i_last;
        unique case (r_phase)
            PH_REF_HI: begin
                o_cmd.kind   = CMD_COPY;
                w_has_cmd    = 1'b1;
                n_flag_bits  = {1'b0, r_flag_bits[7:1]};
                n_flags_left = r_flags_left - 4'd1;
            end
            PH_TOKEN: begin
                if (r_flags_left == 4'd0) begin
                    n_flag_bits  = i_byte;
                    n_flags_left = FLAG_COUNT;
                    w_has_cmd    = i_last;
                end else if (r_flag_bits[0]) begin
                    o_cmd.kind   = CMD_LIT;
                    w_has_cmd    = 1'b1;
                    n_flag_bits  = {1'b0, r_flag_bits[7:1]};
                    n_flags_left = r_flags_left - 4'd1;
                end else begin
                    n_held    = i_byte;
                    w_has_cmd = i_last;
                end
            end
            default: w_has_cmd = i_last;
        endcase
        // end of stream puts the parser back to its start
        if (i_last) begin
            n_flag_bits  = 8'd0;
            n_flags_left = 4'd0;
            n_held       = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TOKEN;
            r_flag_bits  <= 8'd0;
            r_flags_left <= 4'd0;
            r_held       <= 8'd0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_held       <= n_held;
        end
    end

endmodule

// ===== src/lzssd_queue.sv =====
// small command queue between parser and copy engine
module lzssd_queue
    import lzssd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/lzssd_back.sv =====
// copy engine: history window, byte issue, read stage and output register
module lzssd_back
    import lzssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [7:0]          r_mem [2**WIN_BITS];
    logic [7:0]          r_rd;

    t_back_state         r_state, n_state;
    logic [WIN_BITS-1:0] r_iwp, n_iwp;
    logic [WIN_BITS:0]   r_ipc, n_ipc;
    logic [WIN_BITS:0]   r_dist, n_dist;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_clast, n_clast;

    // read stage
    logic                r_p_vld, n_p_vld;
    logic                r_p_zero, n_p_zero;
    logic                r_p_fwd, n_p_fwd;
    logic                r_p_lit_en, n_p_lit_en;
    logic [7:0]          r_p_lit, n_p_lit;
    logic [WIN_BITS-1:0] r_p_waddr, n_p_waddr;
    logic                r_p_last, n_p_last;

    logic                r_o_vld;
    logic [7:0]          r_o_byte;
    logic                r_o_last;
    logic [7:0]          r_last_byte;

    logic                w_out_free;
    logic                w_p_move;
    logic                w_can_issue;
    logic                w_issue;
    logic                w_rd_en;
    logic [7:0]          w_p_value;
    logic [WIN_BITS-1:0] w_src;
    logic [WIN_BITS-1:0] w_d12;
    logic [WIN_BITS:0]   w_ipc_inc;

    assign w_out_free  = !r_o_vld || i_ready;
    assign w_p_move    = r_p_vld && w_out_free;
    assign w_can_issue = !r_p_vld || w_out_free;
    assign w_src       = r_iwp - r_dist[WIN_BITS-1:0];
    assign w_d12       = r_iwp + OFFSET_BIAS - i_cmd.offset;
    assign w_ipc_inc   = (r_ipc == WIN_SIZE) ? r_ipc : r_ipc + 1'b1;

    // a distance of one reads the byte being written this cycle, so take it from the register
    always_comb begin
        if (r_p_zero) begin
            w_p_value = 8'd0;
        end else if (r_p_lit_en) begin
            w_p_value = r_p_lit;
        end else if (r_p_fwd) begin
            w_p_value = r_last_byte;
        end else begin
            w_p_value = r_rd;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && w_can_issue && i_cmd.kind == CMD_COPY) begin
                    n_state = BK_COPY;
                end
            end
            BK_COPY: begin
                if (w_can_issue && r_cnt == 5'd1) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_iwp      = r_iwp;
        n_ipc      = r_ipc;
        n_dist     = r_dist;
        n_cnt      = r_cnt;
        n_clast    = r_clast;
        o_cmd_pop  = 1'b0;
        w_issue    = 1'b0;
        w_rd_en    = 1'b0;
        n_p_zero   = 1'b0;
        n_p_fwd    = 1'b0;
        n_p_lit_en = 1'b0;
        n_p_lit    = i_cmd.lit;
        n_p_waddr  = r_iwp;
        n_p_last   = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && w_can_issue) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_LIT: begin
                            w_issue    = 1'b1;
                            n_p_lit_en = 1'b1;
                            n_iwp      = r_iwp + 1'b1;
                            n_ipc      = w_ipc_inc;
                            if (i_cmd.last) begin
                                n_iwp = '0;
                                n_ipc = '0;
                            end
                        end
                        CMD_COPY: begin
                            n_dist  = (w_d12 == '0) ? WIN_SIZE : {1'b0, w_d12};
                            n_cnt   = {1'b0, i_cmd.len_code} + MIN_LEN;
                            n_clast = i_cmd.last;
                        end
                        default: begin
                            n_iwp = '0;
                            n_ipc = '0;
                        end
                    endcase
                end
            end
            BK_COPY: begin
                if (w_can_issue) begin
                    w_issue  = 1'b1;
                    w_rd_en  = 1'b1;
                    // source lying before the stream start reads as zero
                    n_p_zero = (r_ipc < r_dist);
                    n_p_fwd  = (r_dist == {{WIN_BITS{1'b0}}, 1'b1});
                    n_p_last = (r_cnt == 5'd1);
                    n_iwp    = r_iwp + 1'b1;
                    n_ipc    = w_ipc_inc;
                    n_cnt    = r_cnt - 5'd1;
                    if (r_cnt == 5'd1 && r_clast) begin
                        n_iwp = '0;
                        n_ipc = '0;
                    end
                end
            end
            default: ;
        endcase
        n_p_vld = w_issue || (r_p_vld && !w_p_move);
    end

    // history window
    always_ff @(posedge i_clk) begin
        if (w_p_move) begin
            r_mem[r_p_waddr] <= w_p_value;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_p_zero   <= n_p_zero;
            r_p_fwd    <= n_p_fwd;
            r_p_lit_en <= n_p_lit_en;
            r_p_lit    <= n_p_lit;
            r_p_waddr  <= n_p_waddr;
            r_p_last   <= n_p_last;
        end
        if (w_p_move) begin
            r_o_byte    <= w_p_value;
            r_o_last    <= r_p_last;
            r_last_byte <= w_p_value;
        end
        r_dist  <= n_dist;
        r_cnt   <= n_cnt;
        r_clast <= n_clast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_iwp   <= '0;
            r_ipc   <= '0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iwp   <= n_iwp;
            r_ipc   <= n_ipc;
            r_p_vld <= n_p_vld;
            if (w_p_move) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_byte  = r_o_byte;
    assign o_last  = r_o_last;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the lzss decompressor core
module tb;
    import lzssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 48;
    localparam int RANDOM_ITEMS   = 120;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    lzss_decompressor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // in_byte
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // out_byte
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // decoder state mirrored for prediction
    logic [7:0]          win_mem [WIN_SIZE];
    logic [WIN_BITS-1:0] win_wr;
    logic [WIN_BITS:0]   win_fill;
    logic [7:0]          flag_reg;
    logic [3:0]          flag_cnt;
    t_phase              tok_phase;
    logic [7:0]          ref_lo;

    t_out_byte expected_bytes[$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;

    // payload under construction and its decoded length so far
    logic [7:0] payload_q[$];
    int         stream_len  = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    bit         bursty      = 1'b0;
    int         hold_seq    = 0;

    task automatic clear_stream_state();
        win_wr    = '0;
        win_fill  = '0;
        flag_reg  = '0;
        flag_cnt  = '0;
        tok_phase = PH_TOKEN;
        ref_lo    = '0;
    endtask

    task automatic put_byte(input logic [7:0] v, input logic is_last);
        win_mem[win_wr] = v;
        win_wr = win_wr + 1'b1;
        if (win_fill < WIN_SIZE)
            win_fill = win_fill + 1'b1;
        expected_bytes.push_back('{data: v, last: is_last});
    endtask

    task automatic advance_flag();
        flag_reg = flag_reg >> 1;
        if (flag_cnt > 0)
            flag_cnt = flag_cnt - 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        logic [WIN_BITS-1:0] off;
        logic [WIN_BITS-1:0] src;
        logic [WIN_BITS:0]   back_dist;
        logic [4:0]          len;
        logic [7:0]          v;
        if (tok_phase == PH_REF_HI) begin
            off       = {b[7:4], ref_lo};
            len       = {1'b0, b[3:0]} + MIN_LEN;
            back_dist = {1'b0, win_wr + OFFSET_BIAS - off};
            // zero distance means a full window back
            if (back_dist == 0)
                back_dist = WIN_SIZE;
            for (int i = 0; i < len; i++) begin
                src = win_wr - back_dist[WIN_BITS-1:0];
                v   = (win_fill >= back_dist) ? win_mem[src] : 8'h00;
                put_byte(v, i == len - 1);
            end
            advance_flag();
            tok_phase = PH_TOKEN;
        end else if (flag_cnt == 0) begin
            flag_reg  = b;
            flag_cnt  = FLAG_COUNT;
            tok_phase = PH_TOKEN;
        end else if (flag_reg[0]) begin
            put_byte(b, 1'b1);
            advance_flag();
            tok_phase = PH_TOKEN;
        end else begin
            ref_lo    = b;
            tok_phase = PH_REF_HI;
        end
        if (is_last)
            clear_stream_state();
    endtask

    // output check first: no result can stem from an item accepted at this same edge
    always @(posedge i_clk) begin
        t_out_byte want;
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_SIZE; i++)
                win_mem[i] = 8'h00;
            clear_stream_state();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected item: data %02h last %b",
                                 o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== o_m_axis_tdata || want.last !== o_m_axis_tlast) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected data %02h last %b, got data %02h last %b",
                                     want.data, want.last, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                decode_byte(i_s_axis_tdata, i_s_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    int       hold_seen = 0;
    int       hold_left = 0;
    int       rx_mode   = 0;
    int       rx_left   = 0;
    bit [2:0] rx_tick   = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen       <= hold_seq;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(8, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= (rx_tick[2:1] != 2'b00);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = bursty ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload_q.size(); i++)
            send_byte(payload_q[i], i == payload_q.size() - 1);
        payload_q.delete();
        stream_len = 0;
    endtask

    task automatic add_lit(input logic [7:0] b);
        payload_q.push_back(b);
        stream_len++;
    endtask

    task automatic add_ref_raw(input logic [7:0] lo, input logic [7:0] hi);
        payload_q.push_back(lo);
        payload_q.push_back(hi);
        stream_len += int'(hi[3:0]) + int'(MIN_LEN);
    endtask

    // back_dist counts back from the next byte, 1 to 4096
    task automatic add_ref_dist(input int back_dist, input logic [3:0] len_code);
        logic [WIN_BITS-1:0] off;
        off = WIN_BITS'(((stream_len % WIN_SIZE) + OFFSET_BIAS + WIN_SIZE - back_dist)
                        % WIN_SIZE);
        add_ref_raw(off[7:0], {off[11:8], len_code});
    endtask

    task automatic add_random_ref();
        int reach;
        reach = (stream_len < WIN_SIZE) ? stream_len : WIN_SIZE;
        case ($urandom_range(0, 5))
            0, 1: begin
                if (reach > 0)
                    add_ref_dist($urandom_range(1, (reach < 40) ? reach : 40), 4'($urandom));
                else
                    add_ref_dist($urandom_range(1, WIN_SIZE), 4'($urandom));
            end
            2: begin
                if (reach > 0)
                    add_ref_dist($urandom_range(1, reach), 4'($urandom));
                else
                    add_ref_dist(WIN_SIZE, 4'($urandom));
            end
            // short distance, copy overlaps itself
            3: add_ref_dist($urandom_range(1, 3), 4'($urandom));
            // reaches before the stream start
            4: begin
                if (reach < WIN_SIZE)
                    add_ref_dist($urandom_range(reach + 1, WIN_SIZE), 4'($urandom));
                else
                    add_ref_dist(WIN_SIZE, 4'($urandom));
            end
            default: add_ref_raw(8'($urandom), 8'($urandom));
        endcase
    endtask

    // well-formed stream of n_tok tokens, lit_pct percent of them literals
    task automatic build_stream(input int n_tok, input int lit_pct);
        logic [7:0] flags;
        int         bits_left;
        bits_left = 0;
        flags     = '0;
        for (int t = 0; t < n_tok; t++) begin
            if (bits_left == 0) begin
                for (int k = 0; k < 8; k++)
                    flags[k] = ($urandom_range(0, 99) < lit_pct);
                payload_q.push_back(flags);
                bits_left = 8;
            end
            if (flags[0])
                add_lit(8'($urandom));
            else
                add_random_ref();
            flags = flags >> 1;
            bits_left--;
        end
        // sometimes end on a cut-off reference or a bare flag byte
        if (bits_left > 0 && !flags[0] && $urandom_range(0, 3) == 0)
            payload_q.push_back(8'($urandom));
        else if (bits_left == 0 && $urandom_range(0, 5) == 0)
            payload_q.push_back(8'($urandom));
    endtask

    task automatic test_literals();
        bursty = 1'b0;
        payload_q.push_back(8'hFF);
        add_lit(8'h00); add_lit(8'hFF); add_lit(8'h01); add_lit(8'h80);
        add_lit(8'h7F); add_lit(8'hFE); add_lit(8'h55); add_lit(8'hAA);
        send_payload();
        wait_drained();
    endtask

    task automatic test_references();
        bursty = 1'b1;
        payload_q.push_back(8'b0000_0011);
        add_lit(8'h12);
        add_lit(8'h34);
        add_ref_dist(1, 4'hF);           // longest copy, overlapping
        add_ref_dist(WIN_SIZE, 4'h0);    // zero distance, before stream start
        add_ref_raw(8'h00, 8'h00);       // offset zero
        add_ref_dist(2, 4'h2);
        add_ref_dist(23, 4'h7);
        payload_q.push_back(8'hFF);      // cut-off reference as last byte
        send_payload();
        wait_drained();
    endtask

    task automatic test_stream_edges();
        bursty = 1'b0;
        // lone flag byte as the whole stream
        payload_q.push_back(8'h00);
        send_payload();
        // a fresh stream must not see the previous one's bytes
        payload_q.push_back(8'b1111_0100);
        add_ref_dist(1, 4'h0);
        add_ref_dist(4, 4'h1);
        add_lit(8'h9C);
        send_payload();
        wait_drained();
    endtask

    // long copies reaching far back into the window
    task automatic test_long_copies();
        bursty = 1'b1;
        payload_q.push_back(8'hFF);
        for (int i = 0; i < 8; i++)
            add_lit(8'($urandom));
        for (int g = 0; g < 8; g++) begin
            payload_q.push_back(8'h00);
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(0, 3) == 0)
                    add_ref_dist($urandom_range(1, 4), 4'hF);
                else
                    add_ref_dist($urandom_range(1, stream_len), 4'($urandom_range(12, 15)));
            end
        end
        send_payload();
        wait_drained();
    endtask

    task automatic test_backpressure();
        bursty = 1'b0;
        hold_seq++;
        build_stream(40, 20);
        send_payload();
        wait_drained();
    endtask

    task automatic test_random_streams();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            bursty = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 4) != 0) begin
                build_stream($urandom_range(1, 40), $urandom_range(0, 100));
            end else begin
                // noise: arbitrary bytes, stream cut wherever it ends
                repeat ($urandom_range(1, 20)) payload_q.push_back(8'($urandom));
            end
            send_payload();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_literals();
        test_references();
        test_stream_edges();
        test_long_copies();
        test_backpressure();
        test_random_streams();
        wait_drained();
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
